// ===== hdl/bdq_pkg.sv =====
// shared constants, codes, types and address helpers for the bounded deque
package bdq_pkg;

    // store geometry
    localparam int DEPTH = 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    // payload widths
    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int CNT_W = 7;
    localparam int ST_W  = 2;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_MAX        = 3'd3,
        CMD_MIN        = 3'd4,
        CMD_READ_FWD   = 3'd5,
        CMD_READ_REV   = 3'd6,
        CMD_NONE       = 3'd7
    } cmd_t;

    // status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // compare flags from the shared compare unit
    typedef struct packed {
        logic eq;
        logic gt;
        logic lt;
    } cmp_res_t;

    // physical slot of a logical offset from the head, circular wrap
    function automatic logic [AW-1:0] bdq_wrap(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
            sum = sum - (CW+1)'(DEPTH);
        return sum[AW-1:0];
    endfunction

    // slot in front of the head, circular wrap
    function automatic logic [AW-1:0] bdq_dec(logic [AW-1:0] base);
        logic [AW-1:0] res;
        if (base == '0)
            res = AW'(DEPTH - 1);
        else
            res = base - 1'b1;
        return res;
    endfunction

endpackage

// ===== hdl/bdq_req_if.sv =====
// command channel: valid/ready with command and operand
interface bdq_req_if import bdq_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

// ===== hdl/bdq_rsp_if.sv =====
// result channel: valid/ready with value, count, status and last marker
interface bdq_rsp_if import bdq_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [CNT_W-1:0]        removed_count;
    logic [ST_W-1:0]         status;
    logic                    last;

    modport source (output valid, output result_value, output removed_count,
                    output status, output last, input ready);
    modport sink   (input valid, input result_value, input removed_count,
                    input status, input last, output ready);
endinterface

// ===== hdl/bounded_deque_remove_minmax.sv =====
// bounded deque top level: sequencer, circular store and result register
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    command[2:0], operand_value[31:0]
//  rsp      out  valid/ready    result_value[31:0], removed_count[6:0], status[1:0], last
//
// push, unused code and any command on an empty store: answered from idle, no scan
// remove, max, min, read on n entries: a scan, one entry per cycle while not stalled, through
//   the single registered read port of the store
// reset clears occupancy, head, sequencer and result registers; no clearing pass, store contents undefined
// one result register; a read stalls entry by entry while rsp is not ready,
//   and req is ready only when the sequencer is idle and the result register can load
module bounded_deque_remove_minmax import bdq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CW-1:0]           occ_reg, occ_next;
    cmd_t                    op_reg, op_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] best_reg, best_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           keep_reg, keep_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_val_reg, out_val_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;
    status_t                 out_st_reg, out_st_next;
    logic                    out_last_reg, out_last_next;

    // store port signals
    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [VAL_W-1:0]        ram_wdata, ram_rdata;
    logic signed [VAL_W-1:0] elem;

    // compare unit signals
    logic signed [VAL_W-1:0] cmp_b;
    cmp_res_t                cmp_res;

    logic                    out_free, accept, full, empty;
    logic                    is_read, last_elem, go;
    cmd_t                    cmd;
    logic [CW-1:0]           next_log, kept, removed;
    logic signed [VAL_W-1:0] cand;

    bdq_ram #(
        .WIDTH   (VAL_W),
        .ENTRIES (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign elem  = $signed(ram_rdata);
    assign cmp_b = (op_reg == CMD_REMOVE) ? key_reg : best_reg;

    bdq_cmp u_cmp (
        .a   (elem),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // handshake
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign cmd       = cmd_t'(req.command);
    assign full      = (occ_reg == CW'(DEPTH));
    assign empty     = (occ_reg == '0);

    // scan step decode
    assign is_read   = (op_reg == CMD_READ_FWD) || (op_reg == CMD_READ_REV);
    assign last_elem = ((cnt_reg + 1'b1) == occ_reg);
    assign go        = out_free || (!is_read && !last_elem);
    assign next_log  = (op_reg == CMD_READ_REV) ? (occ_reg - cnt_reg - CW'(2))
                                                : (cnt_reg + 1'b1);
    assign kept      = cmp_res.eq ? keep_reg : (keep_reg + 1'b1);
    assign removed   = occ_reg - kept;
    assign cand      = (cnt_reg == '0) ? elem :
                       ((op_reg == CMD_MAX) ? (cmp_res.gt ? elem : best_reg)
                                            : (cmp_res.lt ? elem : best_reg));

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        best_next      = best_reg;
        cnt_next       = cnt_reg;
        keep_next      = keep_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        out_st_next    = out_st_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = req.operand_value;
        ram_re         = 1'b0;
        ram_raddr      = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = '0;
                    out_cnt_next   = '0;
                    out_st_next    = ST_OK;
                    out_last_next  = 1'b1;
                    case (cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (full)
                                out_st_next = ST_FULL;
                            else
                            begin
                                ram_we   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                                if (cmd == CMD_PUSH_FRONT)
                                begin
                                    ram_waddr = bdq_dec(head_reg);
                                    head_next = bdq_dec(head_reg);
                                end
                                else
                                    ram_waddr = bdq_wrap(head_reg, occ_reg);
                            end
                        end
                        CMD_REMOVE, CMD_MAX, CMD_MIN, CMD_READ_FWD, CMD_READ_REV:
                        begin
                            if (empty)
                            begin
                                out_st_next = ST_EMPTY;
                                if (cmd != CMD_REMOVE)
                                    out_val_next = '1;
                            end
                            else
                            begin
                                // first entry fetch, results come from the scan
                                out_valid_next = out_valid_reg && !rsp.ready;
                                out_val_next   = out_val_reg;
                                out_cnt_next   = out_cnt_reg;
                                out_st_next    = out_st_reg;
                                out_last_next  = out_last_reg;
                                ram_re         = 1'b1;
                                ram_raddr      = bdq_wrap(head_reg,
                                    (cmd == CMD_READ_REV) ? (occ_reg - 1'b1) : '0);
                                op_next        = cmd;
                                key_next       = req.operand_value;
                                cnt_next       = '0;
                                keep_next      = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            out_st_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (go)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    // fetch the next entry while this one is handled
                    if (!last_elem)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = bdq_wrap(head_reg, next_log);
                    end
                    case (op_reg)
                        CMD_REMOVE:
                        begin
                            // compact kept entries towards the head
                            if (!cmp_res.eq)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = bdq_wrap(head_reg, keep_reg);
                                ram_wdata = ram_rdata;
                            end
                            keep_next = kept;
                            if (last_elem)
                            begin
                                occ_next       = kept;
                                out_valid_next = 1'b1;
                                out_val_next   = '0;
                                out_cnt_next   = CNT_W'(removed);
                                out_st_next    = (removed == '0) ? ST_NOT_FOUND : ST_OK;
                                out_last_next  = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        CMD_MAX, CMD_MIN:
                        begin
                            best_next = cand;
                            if (last_elem)
                            begin
                                out_valid_next = 1'b1;
                                out_val_next   = cand;
                                out_cnt_next   = '0;
                                out_st_next    = ST_OK;
                                out_last_next  = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        CMD_READ_FWD, CMD_READ_REV:
                        begin
                            out_valid_next = 1'b1;
                            out_val_next   = elem;
                            out_cnt_next   = '0;
                            out_st_next    = ST_OK;
                            out_last_next  = last_elem;
                            if (last_elem)
                                state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            op_reg        <= CMD_NONE;
            key_reg       <= '0;
            best_reg      <= '0;
            cnt_reg       <= '0;
            keep_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_val_reg   <= '0;
            out_cnt_reg   <= '0;
            out_st_reg    <= ST_OK;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            op_reg        <= op_next;
            key_reg       <= key_next;
            best_reg      <= best_next;
            cnt_reg       <= cnt_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
            out_val_reg   <= out_val_next;
            out_cnt_reg   <= out_cnt_next;
            out_st_reg    <= out_st_next;
            out_last_reg  <= out_last_next;
        end
    end

    // result channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.result_value  = out_val_reg;
    assign rsp.removed_count = out_cnt_reg;
    assign rsp.status        = out_st_reg;
    assign rsp.last          = out_last_reg;

endmodule

// ===== hdl/bdq_ram.sv =====
// generic simple dual-port RAM, one write and one registered read per cycle
module bdq_ram #(
    parameter int WIDTH   = 32,
    parameter int ENTRIES = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bdq_cmp.sv =====
// shared signed compare unit used by remove, max and min
module bdq_cmp import bdq_pkg::*; (
    input  logic signed [VAL_W-1:0] a,
    input  logic signed [VAL_W-1:0] b,
    output cmp_res_t                res
);

    // two signed magnitude compares and one equality
    always_comb
    begin
        res.eq = (a == b);
        res.gt = (a > b);
        res.lt = (a < b);
    end

endmodule

// ===== hdl/bdq_checker.sv =====
// port-level checker for the bounded deque, bound to the top level
module bdq_checker import bdq_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic signed [VAL_W-1:0] rsp_result_value,
    input logic [CNT_W-1:0]        rsp_removed_count,
    input logic [ST_W-1:0]         rsp_status,
    input logic                    rsp_last
);

    // a stalled item holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
            && $stable(rsp_removed_count) && $stable(rsp_status) && $stable(rsp_last))
        else $error("result item changed while stalled");

    // a new command is only taken when the result register can load
    a_req_room: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !rsp_valid || rsp_ready)
        else $error("command taken with result register blocked");

    // only readout produces non-final items, and those are plain
    a_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> rsp_status == ST_OK && rsp_removed_count == '0)
        else $error("non-final item with status or count");

    // a dropped push carries nothing else
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |->
            rsp_result_value == '0 && rsp_removed_count == '0 && rsp_last)
        else $error("full status with stray fields");

    // a non-zero removal count only comes with ok status on a final item
    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_removed_count != '0 |->
            rsp_status == ST_OK && rsp_last && rsp_result_value == '0)
        else $error("removal count with wrong status or value");

endmodule

bind bounded_deque_remove_minmax bdq_checker u_bdq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_result_value  (rsp.result_value),
    .rsp_removed_count (rsp.removed_count),
    .rsp_status        (rsp.status),
    .rsp_last          (rsp.last)
);
